[sv/sdhc_pkg.sv]
// Package for the SD card host controller bus model.
// Holds the register map, command codes, flag masks, data phase type and default sizes.
// No dependencies.
package sdhc_pkg;

   localparam int CardBlocksDefault = 64;
   localparam int WordsPerBlock     = 128;
   localparam int WindowWords       = 128;

   // Word indexes within the register window.
   localparam logic [6:0] W_CMD    = 7'd0;
   localparam logic [6:0] W_ARG    = 7'd2;
   localparam logic [6:0] W_SECCNT = 7'd5;
   localparam logic [6:0] W_RSP0   = 7'd6;
   localparam logic [6:0] W_RSP1   = 7'd8;
   localparam logic [6:0] W_RSP2   = 7'd10;
   localparam logic [6:0] W_RSP3   = 7'd12;
   localparam logic [6:0] W_INFO1  = 7'd14;
   localparam logic [6:0] W_INFO2  = 7'd15;

   // Exact byte offsets with side effects.
   localparam logic [8:0] OFF_CMD  = 9'h000;
   localparam logic [8:0] OFF_FIFO = 9'h060;
   localparam logic [8:0] OFF_SRST = 9'h1C0;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [31:0] FLAG_RSPEND = 32'h0000_0001;
   localparam logic [31:0] FLAG_BRE    = 32'h0000_0100;
   localparam logic [31:0] FLAG_BWE    = 32'h0000_0200;

   // SD command indexes.
   localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
   localparam logic [5:0] CMD_SEND_RCA     = 6'd3;
   localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
   localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
   localparam logic [5:0] CMD_STOP         = 6'd12;
   localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
   localparam logic [5:0] CMD_READ_MULTI   = 6'd18;
   localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
   localparam logic [5:0] CMD_WRITE_MULTI  = 6'd25;
   localparam logic [5:0] CMD_SD_OP_COND   = 6'd41;
   localparam logic [5:0] CMD_APP_CMD      = 6'd55;

   // Canned responses.
   localparam logic [31:0] RSP_R1_IDLE = 32'h0000_0900;
   localparam logic [31:0] RSP_APP     = 32'h0000_0920;
   localparam logic [31:0] RSP_OCR     = 32'hC0FF_8000;
   localparam logic [31:0] RSP_IF_COND = 32'h0000_01AA;
   localparam logic [31:0] RSP_CID     = 32'h5241_3844;
   localparam logic [31:0] RSP_RCA     = 32'h0001_0000;
   localparam logic [31:0] RSP_CSD_HI  = 32'h4000_0000;
   localparam logic [31:0] MIN_CAPACITY = 32'd1024;

   typedef enum logic [2:0] {
      PH_NONE  = 3'b001,
      PH_READ  = 3'b010,
      PH_WRITE = 3'b100
   } phase_type;

   // Where the result word of an accepted transfer comes from.
   typedef enum logic [2:0] {
      SRC_HOLD   = 3'b001,
      SRC_SHADOW = 3'b010,
      SRC_CARD   = 3'b100
   } src_type;

endpackage

[sv/sdhc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the register shadow, the block stage and the card image; no dependencies.
module sdhc_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sd_host_controller_model.sv]
// Top level of the SD card host controller bus model.
// Depends on sdhc_pkg and on sdhc_ram for the shadow, block stage and card image.
//
//   Channel  Direction  Ports                                      Meaning
//   req      in         req_valid/req_ready, opcode, offset, data   one bus access
//   rsp      out        rsp_valid/rsp_ready, read_data              one read word per access
//   csr      in         csr_wr_en, csr_wr_data                      card capacity in blocks
//
// Each access is decoded and applied between the request transfer and the
// result register, so accesses can follow each other in every cycle while
// req_ready stays high. A RAM's registered read data feeds the result directly.
// When a write data phase fills a block that lies on the card, the block stage
// is copied into the card image, during which req_ready is low.
// A stalled result holds req_ready low as well, so there is one result slot.
// Reset is synchronous; it clears all control state and the shadow valid bits.
module sd_host_controller_model #(
   parameter int CARD_BLOCKS = sdhc_pkg::CardBlocksDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [8:0]  req_byte_offset,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   import sdhc_pkg::*;

   localparam int CardWords = CARD_BLOCKS * WordsPerBlock;
   localparam int CardAw    = $clog2(CardWords);
   localparam int IdxW      = $clog2(WordsPerBlock);
   localparam int WinAw     = $clog2(WindowWords);

   // Control and register state.
   phase_type           phase_ff, phase_in;
   logic [IdxW:0]       idx_ff, idx_in;
   logic [31:0]         blk_addr_ff, blk_addr_in;
   logic [31:0]         blk_rem_ff, blk_rem_in;
   logic                prefix_ff, prefix_in;
   logic [31:0]         arg_ff, arg_in;
   logic [31:0]         seccnt_ff, seccnt_in;
   logic [31:0]         rsp0_ff, rsp0_in, rsp1_ff, rsp1_in;
   logic [31:0]         rsp2_ff, rsp2_in, rsp3_ff, rsp3_in;
   logic [31:0]         info1_ff, info1_in, info2_ff, info2_in;
   logic [31:0]         cap_ff;
   logic [WindowWords-1:0] shadow_vld_ff, shadow_vld_in;

   // Commit sweep state.
   logic                sweep_ff, sweep_in;
   logic [IdxW-1:0]     sweep_cnt_ff, sweep_cnt_in;
   logic [CardAw-1:0]   commit_base_ff, commit_base_in;
   logic                pend_ff;
   logic [CardAw-1:0]   pend_addr_ff;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   src_type             src_ff, src_in;
   logic [31:0]         hold_ff, hold_in;
   logic                hold_vld_ff, hold_vld_in;

   // RAM controls.
   logic                sh_wr_en, sh_rd_en;
   logic [31:0]         sh_q;
   logic                st_wr_en;
   logic [31:0]         st_q;
   logic                cd_rd_en;
   logic [31:0]         cd_q;

   logic                accept;
   logic [WinAw-1:0]    word;
   logic [5:0]          cmd;
   logic [IdxW:0]       idx_next;
   logic [31:0]         rem_dec;
   logic [31:0]         cap_eff;
   logic [21:0]         csize;
   logic                in_range;
   logic [CardAw-1:0]   card_rd_addr;
   logic [CardAw-1:0]   blk_base;
   logic [38:0]         card_cat;
   logic [38:0]         base_cat;

   assign accept    = req_valid && req_ready;
   assign req_ready = !sweep_ff && !pend_ff && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign word      = req_byte_offset[8:2];
   assign cmd       = req_write_data[5:0];
   assign in_range  = blk_addr_ff < 32'(CARD_BLOCKS);
   assign card_cat  = {blk_addr_ff, idx_ff[IdxW-1:0]};
   assign base_cat  = {blk_addr_ff, {IdxW{1'b0}}};
   assign card_rd_addr = card_cat[CardAw-1:0];
   assign blk_base     = base_cat[CardAw-1:0];
   assign idx_next  = idx_ff + 1'b1;
   assign rem_dec   = (blk_rem_ff != 32'd0) ? blk_rem_ff - 32'd1 : 32'd0;
   assign cap_eff   = (cap_ff < MIN_CAPACITY) ? MIN_CAPACITY : cap_ff;
   assign csize     = cap_eff[31:10] - 22'd1;

   always_comb begin
      phase_in       = phase_ff;
      idx_in         = idx_ff;
      blk_addr_in    = blk_addr_ff;
      blk_rem_in     = blk_rem_ff;
      prefix_in      = prefix_ff;
      arg_in         = arg_ff;
      seccnt_in      = seccnt_ff;
      rsp0_in        = rsp0_ff;
      rsp1_in        = rsp1_ff;
      rsp2_in        = rsp2_ff;
      rsp3_in        = rsp3_ff;
      info1_in       = info1_ff;
      info2_in       = info2_ff;
      shadow_vld_in  = shadow_vld_ff;
      sweep_in       = sweep_ff;
      sweep_cnt_in   = sweep_cnt_ff;
      commit_base_in = commit_base_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      src_in         = src_ff;
      hold_in        = hold_ff;
      hold_vld_in    = hold_vld_ff;
      sh_wr_en       = 1'b0;
      sh_rd_en       = 1'b0;
      st_wr_en       = 1'b0;
      cd_rd_en       = 1'b0;

      // The commit sweep walks the stage one word a cycle.
      if (sweep_ff) begin
         sweep_cnt_in = sweep_cnt_ff + 1'b1;
         if (sweep_cnt_ff == {IdxW{1'b1}}) begin
            sweep_in = 1'b0;
         end
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         src_in       = SRC_HOLD;
         hold_in      = 32'd0;
         if (req_opcode == OP_READ) begin
            if (req_byte_offset == OFF_FIFO) begin
               if (phase_ff == PH_READ) begin
                  if (in_range) begin
                     src_in   = SRC_CARD;
                     cd_rd_en = 1'b1;
                  end
                  idx_in = idx_next;
                  if (idx_next[IdxW]) begin
                     blk_rem_in = rem_dec;
                     if (rem_dec != 32'd0) begin
                        blk_addr_in = blk_addr_ff + 32'd1;
                        idx_in      = '0;
                        info2_in    = info2_ff | FLAG_BRE;
                     end else begin
                        phase_in = PH_NONE;
                        info2_in = info2_ff & ~FLAG_BRE;
                     end
                  end
               end
            end else begin
               case (word)
                  W_ARG:    hold_in = arg_ff;
                  W_SECCNT: hold_in = seccnt_ff;
                  W_RSP0:   hold_in = rsp0_ff;
                  W_RSP1:   hold_in = rsp1_ff;
                  W_RSP2:   hold_in = rsp2_ff;
                  W_RSP3:   hold_in = rsp3_ff;
                  W_INFO1:  hold_in = info1_ff;
                  W_INFO2:  hold_in = info2_ff;
                  default: begin
                     src_in      = SRC_SHADOW;
                     sh_rd_en    = 1'b1;
                     hold_vld_in = shadow_vld_ff[word];
                  end
               endcase
            end
         end else if (req_byte_offset == OFF_FIFO) begin
            if (phase_ff == PH_WRITE) begin
               st_wr_en = 1'b1;
               idx_in   = idx_next;
               if (idx_next[IdxW]) begin
                  if (in_range) begin
                     sweep_in       = 1'b1;
                     sweep_cnt_in   = '0;
                     commit_base_in = blk_base;
                  end
                  idx_in     = '0;
                  blk_rem_in = rem_dec;
                  if (rem_dec != 32'd0) begin
                     blk_addr_in = blk_addr_ff + 32'd1;
                  end else begin
                     phase_in = PH_NONE;
                     info2_in = info2_ff & ~FLAG_BWE;
                  end
               end
            end
         end else begin
            // Plain store of the written word.
            case (word)
               W_ARG:    arg_in    = req_write_data;
               W_SECCNT: seccnt_in = req_write_data;
               W_RSP0:   rsp0_in   = req_write_data;
               W_RSP1:   rsp1_in   = req_write_data;
               W_RSP2:   rsp2_in   = req_write_data;
               W_RSP3:   rsp3_in   = req_write_data;
               W_INFO1:  info1_in  = req_write_data;
               W_INFO2:  info2_in  = req_write_data;
               default: begin
                  sh_wr_en            = 1'b1;
                  shadow_vld_in[word] = 1'b1;
               end
            endcase
            if (req_byte_offset == OFF_SRST) begin
               phase_in   = PH_NONE;
               idx_in     = '0;
               blk_rem_in = 32'd0;
               prefix_in  = 1'b0;
               info1_in   = 32'd0;
               info2_in   = 32'd0;
            end else if (req_byte_offset == OFF_CMD) begin
               rsp0_in = RSP_R1_IDLE;
               rsp1_in = 32'd0;
               rsp2_in = 32'd0;
               rsp3_in = 32'd0;
               case (cmd)
                  CMD_READ_SINGLE, CMD_READ_MULTI: begin
                     blk_addr_in = arg_ff;
                     phase_in    = PH_READ;
                     blk_rem_in  = (cmd == CMD_READ_MULTI && seccnt_ff != 32'd0) ?
                                   seccnt_ff : 32'd1;
                     idx_in      = '0;
                     info2_in    = info2_ff | FLAG_BRE;
                  end
                  CMD_WRITE_SINGLE, CMD_WRITE_MULTI: begin
                     blk_addr_in = arg_ff;
                     phase_in    = PH_WRITE;
                     blk_rem_in  = (cmd == CMD_WRITE_MULTI && seccnt_ff != 32'd0) ?
                                   seccnt_ff : 32'd1;
                     idx_in      = '0;
                     info2_in    = info2_ff | FLAG_BWE;
                  end
                  CMD_STOP: phase_in = PH_NONE;
                  CMD_SD_OP_COND: begin
                     if (prefix_ff) begin
                        rsp0_in = RSP_OCR;
                     end
                  end
                  CMD_SEND_IF_COND: rsp0_in = RSP_IF_COND;
                  CMD_APP_CMD:      rsp0_in = RSP_APP;
                  CMD_ALL_SEND_CID: begin
                     rsp0_in = RSP_CID;
                     rsp1_in = RSP_CID;
                     rsp2_in = RSP_CID;
                     rsp3_in = RSP_CID;
                  end
                  CMD_SEND_RCA: rsp0_in = RSP_RCA;
                  CMD_SEND_CSD: begin
                     // CSD version 2: C_SIZE split over the two middle words.
                     rsp3_in = RSP_CSD_HI;
                     rsp2_in = {26'd0, csize[21:16]};
                     rsp1_in = {csize[15:0], 16'd0};
                     rsp0_in = 32'd0;
                  end
                  default: ;
               endcase
               prefix_in = (cmd == CMD_APP_CMD);
               info1_in  = info1_ff | FLAG_RSPEND;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_NONE;
         idx_ff        <= '0;
         blk_addr_ff   <= 32'd0;
         blk_rem_ff    <= 32'd0;
         prefix_ff     <= 1'b0;
         arg_ff        <= 32'd0;
         seccnt_ff     <= 32'd0;
         rsp0_ff       <= 32'd0;
         rsp1_ff       <= 32'd0;
         rsp2_ff       <= 32'd0;
         rsp3_ff       <= 32'd0;
         info1_ff      <= 32'd0;
         info2_ff      <= 32'd0;
         cap_ff        <= 32'd0;
         shadow_vld_ff <= '0;
         sweep_ff      <= 1'b0;
         sweep_cnt_ff  <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         src_ff        <= SRC_HOLD;
      end else begin
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         blk_addr_ff   <= blk_addr_in;
         blk_rem_ff    <= blk_rem_in;
         prefix_ff     <= prefix_in;
         arg_ff        <= arg_in;
         seccnt_ff     <= seccnt_in;
         rsp0_ff       <= rsp0_in;
         rsp1_ff       <= rsp1_in;
         rsp2_ff       <= rsp2_in;
         rsp3_ff       <= rsp3_in;
         info1_ff      <= info1_in;
         info2_ff      <= info2_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         shadow_vld_ff <= shadow_vld_in;
         sweep_ff      <= sweep_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         pend_ff       <= sweep_ff;
         rsp_valid_ff  <= rsp_valid_in;
         src_ff        <= src_in;
      end
   end

   always_ff @(posedge clock) begin
      commit_base_ff <= commit_base_in;
      pend_addr_ff   <= commit_base_ff | CardAw'(sweep_cnt_ff);
      hold_ff        <= hold_in;
      hold_vld_ff    <= hold_vld_in;
   end

   always_comb begin
      case (src_ff)
         SRC_SHADOW: rsp_read_data = hold_vld_ff ? sh_q : 32'd0;
         SRC_CARD:   rsp_read_data = cd_q;
         default:    rsp_read_data = hold_ff;
      endcase
   end

   sdhc_ram #(.WIDTH(32), .DEPTH(WindowWords)) u_shadow (
      .clock   (clock),
      .wr_en   (sh_wr_en),
      .wr_addr (word),
      .wr_data (req_write_data),
      .rd_en   (sh_rd_en),
      .rd_addr (word),
      .rd_data (sh_q)
   );

   sdhc_ram #(.WIDTH(32), .DEPTH(WordsPerBlock)) u_stage (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (idx_ff[IdxW-1:0]),
      .wr_data (req_write_data),
      .rd_en   (sweep_ff),
      .rd_addr (sweep_cnt_ff),
      .rd_data (st_q)
   );

   sdhc_ram #(.WIDTH(32), .DEPTH(CardWords)) u_card (
      .clock   (clock),
      .wr_en   (pend_ff),
      .wr_addr (pend_addr_ff),
      .wr_data (st_q),
      .rd_en   (cd_rd_en),
      .rd_addr (card_rd_addr),
      .rd_data (cd_q)
   );

   // No transfer may land while the stage is being copied to the card.
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (sweep_ff || pend_ff) |-> !req_ready)
      else $error("request accepted during commit sweep");

   // Every accepted access yields a result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted access gave no result");

   // During a write phase the FIFO index never rests at the block end.
   a_write_idx: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WRITE) |-> !idx_ff[IdxW])
      else $error("write phase FIFO index out of range");

   // A sweep runs only right after the last word of a block was written.
   a_sweep_start: assert property (@(posedge clock) disable iff (reset)
      $rose(sweep_ff) |-> $past(accept && req_opcode == OP_WRITE))
      else $error("commit sweep started without a FIFO write");

endmodule
